// File: src/jse_pkg.sv
package jse_pkg;

    localparam int NUM_MASK_REGS = 8;
    localparam int MASK_WIDTH    = 32;
    localparam int CFG_IDX_WIDTH = 4;

    localparam logic [MASK_WIDTH-1:0] MASK_RESET [NUM_MASK_REGS] = '{
        32'hffff_ffff, 32'h0000_8004, 32'h1000_0000, 32'h0000_0000,
        32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000
    };

    localparam logic [7:0] CH_BACKSPACE = 8'h08;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_NEWLINE   = 8'h0a;
    localparam logic [7:0] CH_FORMFEED  = 8'h0c;
    localparam logic [7:0] CH_RETURN    = 8'h0d;
    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_SLASH     = 8'h2f;
    localparam logic [7:0] CH_BACKSLASH = 8'h5c;
    localparam logic [7:0] CH_ZERO      = 8'h30;
    localparam logic [7:0] CH_LOWER_A   = 8'h61;
    localparam logic [7:0] CH_LOWER_B   = 8'h62;
    localparam logic [7:0] CH_LOWER_F   = 8'h66;
    localparam logic [7:0] CH_LOWER_N   = 8'h6e;
    localparam logic [7:0] CH_LOWER_R   = 8'h72;
    localparam logic [7:0] CH_LOWER_T   = 8'h74;
    localparam logic [7:0] CH_LOWER_U   = 8'h75;

    // Number of output bytes per class, minus one
    localparam logic [2:0] LAST_STEP_PLAIN = 3'd0;
    localparam logic [2:0] LAST_STEP_SHORT = 3'd1;
    localparam logic [2:0] LAST_STEP_HEX   = 3'd5;

    typedef enum logic [1:0] {
        KIND_PLAIN,
        KIND_SHORT,
        KIND_HEX
    } kind_t;

    // data: plain byte, second char of a short escape, or raw byte for hex
    typedef struct packed {
        kind_t      kind;
        logic [7:0] data;
        logic       last;
    } entry_t;

    function automatic logic [7:0] hex_digit(input logic [3:0] v);
        logic [7:0] r;
        if (v < 4'd10)
            r = CH_ZERO + {4'd0, v};
        else
            r = CH_LOWER_A + {4'd0, v} - 8'd10;
        return r;
    endfunction

endpackage

// File: src/jse_front.sv
module jse_front (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    input  logic [jse_pkg::CFG_IDX_WIDTH-1:0] cfg_index,
    input  logic [jse_pkg::MASK_WIDTH-1:0]   cfg_data,
    input  logic [7:0]                       in_byte,
    input  logic                             in_last,
    output jse_pkg::entry_t                  entry
);
    import jse_pkg::*;

    logic [MASK_WIDTH-1:0] mask_reg [NUM_MASK_REGS];
    logic                  flagged;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_MASK_REGS; i++)
                mask_reg[i] <= MASK_RESET[i];
        end
        else if (cfg_valid && cfg_index < CFG_IDX_WIDTH'(NUM_MASK_REGS))
        begin
            mask_reg[cfg_index[2:0]] <= cfg_data;
        end
    end

    assign flagged = mask_reg[in_byte[7:5]][in_byte[4:0]];

    // Classify the byte into plain, two-byte escape or six-byte hex escape
    always_comb
    begin
        entry.last = in_last;
        entry.kind = KIND_PLAIN;
        entry.data = in_byte;
        if (flagged)
        begin
            entry.kind = KIND_SHORT;
            unique case (in_byte)
                CH_BACKSPACE: entry.data = CH_LOWER_B;
                CH_NEWLINE:   entry.data = CH_LOWER_N;
                CH_RETURN:    entry.data = CH_LOWER_R;
                CH_TAB:       entry.data = CH_LOWER_T;
                CH_FORMFEED:  entry.data = CH_LOWER_F;
                CH_QUOTE, CH_BACKSLASH, CH_SLASH: entry.data = in_byte;
                default:
                begin
                    entry.kind = KIND_HEX;
                    entry.data = in_byte;
                end
            endcase
        end
    end

endmodule

// File: src/jse_queue.sv
module jse_queue #(
    parameter int DEPTH = 4
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr_en,
    input  jse_pkg::entry_t wr_entry,
    output logic            full,
    input  logic            rd_en,
    output logic            rd_valid,
    output jse_pkg::entry_t rd_entry
);
    import jse_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    entry_t             slot_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic               do_wr;
    logic               do_rd;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign do_wr    = wr_en && !full;
    assign do_rd    = rd_en && rd_valid;
    assign rd_entry = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_wr)
            slot_reg[wr_ptr_reg] <= wr_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (do_rd)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (do_wr && !do_rd)
                count_reg <= count_reg + 1'b1;
            else if (do_rd && !do_wr)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

// File: src/jse_back.sv
module jse_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            head_valid,
    input  jse_pkg::entry_t head,
    output logic            head_pop,
    output logic            empty,
    input  logic            pop,
    output logic [7:0]      out_byte,
    output logic            out_last
);
    import jse_pkg::*;

    logic [2:0] step_reg;
    logic [2:0] last_step;
    logic [7:0] byte_next;
    logic       out_valid_reg;
    logic [7:0] out_byte_reg;
    logic       out_last_reg;
    logic       load;
    logic       final_step;

    always_comb
    begin
        unique case (head.kind)
            KIND_PLAIN: last_step = LAST_STEP_PLAIN;
            KIND_SHORT: last_step = LAST_STEP_SHORT;
            KIND_HEX:   last_step = LAST_STEP_HEX;
            default:    last_step = LAST_STEP_PLAIN;
        endcase
    end

    always_comb
    begin
        byte_next = head.data;
        if (head.kind != KIND_PLAIN)
        begin
            case (step_reg)
                3'd0:    byte_next = CH_BACKSLASH;
                3'd1:    byte_next = (head.kind == KIND_HEX) ? CH_LOWER_U : head.data;
                3'd2,
                3'd3:    byte_next = CH_ZERO;
                3'd4:    byte_next = hex_digit(head.data[7:4]);
                default: byte_next = hex_digit(head.data[3:0]);
            endcase
        end
    end

    // Advance when the output stage is free or being drained this cycle
    assign load       = head_valid && (!out_valid_reg || pop);
    assign final_step = (step_reg == last_step);
    assign head_pop   = load && final_step;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                step_reg      <= final_step ? 3'd0 : step_reg + 1'b1;
                out_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_byte_reg <= byte_next;
            out_last_reg <= head.last && final_step;
        end
    end

    assign empty    = !out_valid_reg;
    assign out_byte = out_byte_reg;
    assign out_last = out_last_reg;

endmodule

// File: src/json_string_escaper.sv
// JSON string escaper.
// Input queue side: drive in_byte/in_last with push; a transaction happens when
// push is high and full is low. One byte per cycle is accepted while the
// internal queue has room.
// Output queue side: out_byte/out_last hold the oldest result while empty is
// low; pop takes it. out_last marks the final byte of an input with in_last.
// Each input yields 1 output byte (plain), 2 (short escape such as \n) or 6
// (\u00hh). The back end emits one output byte per cycle while pop keeps the
// output stage drained, so plain bytes sustain one input per cycle; an escape
// holds the queue head until all its output bytes are emitted. The first output
// byte passes through a queue slot and then the output register before pop.
// A stalled receiver holds the output register; the queue of QUEUE_DEPTH
// entries keeps accepting until full rises.
// Configuration: cfg_index 0..7 selects an escape_mask register (bit n of
// register r flags byte 32*r+n); other indexes are ignored. cfg_ready is
// always high. Write only while the block is idle.
// Reset (rst_n low, asynchronous) empties the queue and output stage and loads
// the default map: control bytes, quote, slash and backslash escaped.
module json_string_escaper #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              push,
    output logic                              full,
    input  logic [7:0]                        in_byte,
    input  logic                              in_last,
    output logic                              empty,
    input  logic                              pop,
    output logic [7:0]                        out_byte,
    output logic                              out_last,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [jse_pkg::CFG_IDX_WIDTH-1:0] cfg_index,
    input  logic [jse_pkg::MASK_WIDTH-1:0]    cfg_data
);
    import jse_pkg::*;

    entry_t front_entry;
    entry_t head_entry;
    logic   head_valid;
    logic   head_pop;

    assign cfg_ready = 1'b1;

    jse_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_byte   (in_byte),
        .in_last   (in_last),
        .entry     (front_entry)
    );

    jse_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (push),
        .wr_entry (front_entry),
        .full     (full),
        .rd_en    (head_pop),
        .rd_valid (head_valid),
        .rd_entry (head_entry)
    );

    jse_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head_entry),
        .head_pop   (head_pop),
        .empty      (empty),
        .pop        (pop),
        .out_byte   (out_byte),
        .out_last   (out_last)
    );

endmodule
